### src/ctrks_pkg.sv
// ----------------------------------------------------------------------------
// ctrks_pkg
// shared constants and aes round functions for the counter-mode keystream core
// ----------------------------------------------------------------------------
package ctrks_pkg;

  localparam int AES_ROUNDS  = 10;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int BLK_W       = 128;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 2'd3;

  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [2047:0] SBOX_TABLE = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [2047:0] sh;
    sh = SBOX_TABLE >> {~x, 3'b000};
    return sh[7:0];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] v;
    case (rnd)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [BLK_W-1:0] key_next(input logic [BLK_W-1:0] k,
                                                 input logic [3:0] rnd);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    t  = t ^ {rcon(rnd), 24'h000000};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s_in,
                                                  input logic last);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] o [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [BLK_W-1:0] r;
    for (int i = 0; i < 16; i++) begin
      s[i] = s_in[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i+4*c] = sbox(s[i+4*((c+i)%4)]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      o[4*c]   = last ? a0 : (a0 ^ al ^ xtime(a0 ^ a1));
      o[4*c+1] = last ? a1 : (a1 ^ al ^ xtime(a1 ^ a2));
      o[4*c+2] = last ? a2 : (a2 ^ al ^ xtime(a2 ^ a3));
      o[4*c+3] = last ? a3 : (a3 ^ al ^ xtime(a3 ^ a0));
    end
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = o[i];
    end
    return r;
  endfunction

endpackage

### src/ctrks_fifo.sv
// ----------------------------------------------------------------------------
// ctrks_fifo
// small synchronous queue used at the input and between core and result port
// ----------------------------------------------------------------------------
module ctrks_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ctrks_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= din;
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### src/ctrks_core.sv
// ----------------------------------------------------------------------------
// ctrks_core
// key expansion, iterative aes round unit, keystream prefetch and byte xor
// ----------------------------------------------------------------------------
module ctrks_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ctrks_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctrks_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                               item_valid,
  input  logic                               item_cmd,
  input  logic [7:0]                         item_data,
  output logic                               item_pop,
  output logic                               res_push,
  output logic [7:0]                         res_byte,
  input  logic                               res_full
);

  localparam logic [1:0] ENG_IDLE = 2'd0;
  localparam logic [1:0] ENG_KEXP = 2'd1;
  localparam logic [1:0] ENG_ENC  = 2'd2;
  localparam logic [3:0] LAST_RND = 4'(ctrks_pkg::AES_ROUNDS);

  logic [ctrks_pkg::CFG_W-1:0] key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic [1:0]                  eng_r;
  logic [3:0]                  rnd_r;
  logic [127:0]                kw_r, st_r, ctr_r, ks_cur_r, ks_nxt_r;
  logic [127:0]                rk_r [ctrks_pkg::AES_ROUNDS+1];
  logic                        nv_r;
  logic [3:0]                  pos_r;

  logic         is_restart, at_block, do_data;
  logic [127:0] ks_sel, ks_shift, rk_cur, round_out, key_step;

  assign is_restart = item_valid & (item_cmd == ctrks_pkg::CMD_RESTART);
  assign at_block   = (pos_r == 4'd0);
  assign do_data    = item_valid & (item_cmd == ctrks_pkg::CMD_DATA) & ~res_full &
                      (~at_block | nv_r);
  assign item_pop   = is_restart | do_data;
  assign res_push   = do_data;

  assign ks_sel    = at_block ? ks_nxt_r : ks_cur_r;
  assign ks_shift  = ks_sel >> {~pos_r, 3'b000};
  assign res_byte  = item_data ^ ks_shift[7:0];

  assign rk_cur    = rk_r[rnd_r];
  assign round_out = ctrks_pkg::aes_round(st_r, rnd_r == LAST_RND) ^ rk_cur;
  assign key_step  = ctrks_pkg::key_next(kw_r, rnd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      iv_hi_r  <= '0;
      iv_lo_r  <= '0;
      eng_r    <= ENG_IDLE;
      rnd_r    <= '0;
      ctr_r    <= '0;
      ks_cur_r <= '0;
      ks_nxt_r <= '0;
      nv_r     <= 1'b0;
      pos_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ctrks_pkg::CFG_KEY_HIGH: key_hi_r <= cfg_wdata;
          ctrks_pkg::CFG_KEY_LOW:  key_lo_r <= cfg_wdata;
          ctrks_pkg::CFG_IV_HIGH:  iv_hi_r  <= cfg_wdata;
          ctrks_pkg::CFG_IV_LOW:   iv_lo_r  <= cfg_wdata;
          default: ;
        endcase
      end

      unique case (eng_r)
        ENG_KEXP: begin
          rk_r[rnd_r] <= key_step;
          kw_r        <= key_step;
          if (rnd_r == LAST_RND) begin
            eng_r <= ENG_ENC;
            st_r  <= ctr_r ^ rk_r[0];
            ctr_r <= ctr_r + 1'b1;
            rnd_r <= 4'd1;
          end else begin
            rnd_r <= rnd_r + 1'b1;
          end
        end
        ENG_ENC: begin
          st_r <= round_out;
          if (rnd_r == LAST_RND) begin
            ks_nxt_r <= round_out;
            nv_r     <= 1'b1;
            eng_r    <= ENG_IDLE;
          end else begin
            rnd_r <= rnd_r + 1'b1;
          end
        end
        default: ;
      endcase

      if (do_data) begin
        pos_r <= pos_r + 1'b1;
        if (at_block) begin
          ks_cur_r <= ks_nxt_r;
          nv_r     <= 1'b0;
          eng_r    <= ENG_ENC;
          st_r     <= ctr_r ^ rk_r[0];
          rnd_r    <= 4'd1;
          ctr_r    <= ctr_r + 1'b1;
        end
      end

      if (is_restart) begin
        eng_r   <= ENG_KEXP;
        kw_r    <= {key_hi_r, key_lo_r};
        rk_r[0] <= {key_hi_r, key_lo_r};
        rnd_r   <= 4'd1;
        ctr_r   <= {iv_hi_r, iv_lo_r};
        pos_r   <= '0;
        nv_r    <= 1'b0;
      end
    end
  end

endmodule

### src/aes128_ctr_keystream_cipher_core.sv
// ----------------------------------------------------------------------------
// aes128_ctr_keystream_cipher_core
// aes-128 counter mode byte cipher with queue-style request and result ports
// ----------------------------------------------------------------------------
// request path: input queue, then the core's byte xor, then the result queue, when the next keystream block is ready
// restart: all round keys are expanded, then the first keystream block is encrypted, before the first byte
// throughput: one byte per cycle while the result queue has room and no restart is pending; the iterative
//   round unit refills the next keystream block before the bytes of the current block are used up
// reset: synchronous active low, clears queues, config registers and counter
// ----------------------------------------------------------------------------
module aes128_ctr_keystream_cipher_core #(
  parameter int QUEUE_DEPTH = ctrks_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ctrks_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctrks_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                            in_push,
  input  logic                            in_command,
  input  logic [7:0]                      in_data_byte,
  output logic                            in_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [7:0]                      out_byte
);

  logic       q_empty, q_pop, q_cmd, r_push, r_full;
  logic [7:0] q_data, r_byte;

  ctrks_fifo #(.WIDTH(9), .DEPTH(QUEUE_DEPTH)) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   ({in_command, in_data_byte}),
    .full  (in_full),
    .pop   (q_pop),
    .dout  ({q_cmd, q_data}),
    .empty (q_empty)
  );

  ctrks_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (~q_empty),
    .item_cmd   (q_cmd),
    .item_data  (q_data),
    .item_pop   (q_pop),
    .res_push   (r_push),
    .res_byte   (r_byte),
    .res_full   (r_full)
  );

  ctrks_fifo #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .din   (r_byte),
    .full  (r_full),
    .pop   (out_pop),
    .dout  (out_byte),
    .empty (out_empty)
  );

endmodule

### test/tb_aes128_ctr_keystream_cipher_core.sv
// ----------------------------------------------------------------------------
// tb_aes128_ctr_keystream_cipher_core
// Self-checking bench for the AES-128 counter-mode byte cipher. Each accepted
// request updates an in-bench AES-128 CTR predictor. The predictor queues the
// byte it expects, and every popped byte is compared in order. Key and
// counter settings change only while the core is idle. Both sides idle at
// random, and in one phase the consumer stalls for a long time to fill the
// core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aes128_ctr_keystream_cipher_core;

  localparam logic [0:255][7:0] SUB_BYTES = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };
  localparam int CYCLE_LIMIT = 400000;

  class keystream_scoreboard;
    logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    logic [127:0] ctr, ks_block;
    logic [3:0]   pos;
    logic [127:0] rkey [11];
    logic [7:0]   expected_bytes [$];
    int           n_bytes, n_restarts;

    function new();
      key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
      ctr = '0; ks_block = '0; pos = '0;
      n_bytes = 0; n_restarts = 0;
    endfunction

    function void write_reg(logic [ctrks_pkg::CFG_IDX_W-1:0] idx, logic [63:0] v);
      case (idx)
        ctrks_pkg::CFG_KEY_HIGH: key_hi = v;
        ctrks_pkg::CFG_KEY_LOW:  key_lo = v;
        ctrks_pkg::CFG_IV_HIGH:  iv_hi = v;
        ctrks_pkg::CFG_IV_LOW:   iv_lo = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] dbl(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function void expand();
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
      w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
      for (int i = 4; i < 44; i++) begin
        t = w[i-1];
        if (i % 4 == 0) begin
          t = {SUB_BYTES[t[23:16]], SUB_BYTES[t[15:8]], SUB_BYTES[t[7:0]],
               SUB_BYTES[t[31:24]]} ^ {rc, 24'h0};
          rc = dbl(rc);
        end
        w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++) rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function logic [127:0] encrypt(logic [127:0] blk);
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   x;
      logic [127:0] st;
      st = blk ^ rkey[0];
      for (int r = 1; r <= 10; r++) begin
        for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
        // byte shift across columns, then substitution
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) t[i+4*c] = SUB_BYTES[s[i+4*((c+i)%4)]];
        if (r != 10) begin
          for (int c = 0; c < 4; c++) begin
            x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            for (int i = 0; i < 4; i++)
              s[4*c+i] = t[4*c+i] ^ x ^ dbl(t[4*c+i] ^ t[4*c+(i+1)%4]);
          end
        end else begin
          s = t;
        end
        for (int i = 0; i < 16; i++) st[127-8*i -: 8] = s[i];
        st = st ^ rkey[r];
      end
      return st;
    endfunction

    function void note_request(logic cmd, logic [7:0] d);
      if (cmd == ctrks_pkg::CMD_RESTART) begin
        expand();
        ctr = {iv_hi, iv_lo};
        pos = '0;
        n_restarts++;
      end else begin
        if (pos == 0) begin
          ks_block = encrypt(ctr);
          ctr = ctr + 128'd1;
        end
        expected_bytes.push_back(d ^ ks_block[127-8*pos -: 8]);
        pos = pos + 4'd1;
        n_bytes++;
      end
    endfunction

    function string check_byte(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) return $sformatf("unexpected byte %02h", got);
      want = expected_bytes.pop_front();
      if (got !== want) return $sformatf("out_byte %02h, expected %02h", got, want);
      return "";
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [ctrks_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ctrks_pkg::CFG_W-1:0]     cfg_wdata;
  logic                            in_push;
  logic                            in_command;
  logic [7:0]                      in_data_byte;
  logic                            in_full;
  logic                            out_empty;
  logic                            out_pop;
  logic [7:0]                      out_byte;

  keystream_scoreboard sb;
  int errors;
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;
  bit stall_req;
  bit full_seen;

  aes128_ctr_keystream_cipher_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_push(in_push), .in_command(in_command),
    .in_data_byte(in_data_byte), .in_full(in_full), .out_empty(out_empty),
    .out_pop(out_pop), .out_byte(out_byte)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  task report(string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (stall_req && in_full) full_seen = 1'b1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL aes128_ctr_keystream_cipher_core");
      $finish;
    end
  end

  // result side
  initial begin
    string msg;
    out_pop = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_pop && !out_empty) begin
        msg = sb.check_byte(out_byte);
        if (msg != "") report(msg);
      end
      if (stall_req) begin
        out_pop <= 1'b0;
        repeat (300) @(posedge clk);
        stall_req = 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  task send(logic cmd, logic [7:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= d;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_request(cmd, d);
  endtask

  task settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task write_cfg(logic [ctrks_pkg::CFG_IDX_W-1:0] idx, logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task load_settings(logic [63:0] kh, logic [63:0] kl, logic [63:0] ih, logic [63:0] il);
    write_cfg(ctrks_pkg::CFG_KEY_HIGH, kh);
    write_cfg(ctrks_pkg::CFG_KEY_LOW, kl);
    write_cfg(ctrks_pkg::CFG_IV_HIGH, ih);
    write_cfg(ctrks_pkg::CFG_IV_LOW, il);
    cfg_we <= 1'b0;
  endtask

  task random_phase(int n);
    send(ctrks_pkg::CMD_RESTART, 8'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) send(ctrks_pkg::CMD_RESTART, 8'($urandom));
      else send(ctrks_pkg::CMD_DATA, 8'($urandom));
    end
  endtask

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    sb = new();
    errors = 0;
    cycles = 0;
    stall_req = 1'b0;
    full_seen = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_push = 1'b0;
    in_command = ctrks_pkg::CMD_DATA;
    in_data_byte = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // known key, counter at all ones so it wraps to zero
    load_settings(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    send(ctrks_pkg::CMD_RESTART, 8'h00);
    send(ctrks_pkg::CMD_DATA, 8'h00);
    send(ctrks_pkg::CMD_DATA, 8'hff);
    for (int i = 0; i < 16; i++) send(ctrks_pkg::CMD_DATA, 8'($urandom));
    send(ctrks_pkg::CMD_RESTART, 8'hff);
    send(ctrks_pkg::CMD_DATA, 8'haa);
    send(ctrks_pkg::CMD_DATA, 8'h55);
    settle();

    load_settings('1, '1, '0, '0);
    send_idle_pct = 28;
    recv_idle_pct = 46;
    random_phase(260);
    settle();

    load_settings(rand64(), rand64(), rand64(), '1);
    send_idle_pct = 46;
    recv_idle_pct = 28;
    random_phase(260);
    settle();

    load_settings(rand64(), rand64(), rand64(), rand64());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req = 1'b1;
    random_phase(260);
    settle();

    $display("covered %0d data bytes and %0d restarts over four key and counter settings",
             sb.n_bytes, sb.n_restarts);
    $display("input back-pressure %0s during the long consumer stall",
             full_seen ? "was seen" : "was not seen");
    if (errors == 0) begin
      $display("PASS aes128_ctr_keystream_cipher_core");
    end else begin
      $display("FAIL aes128_ctr_keystream_cipher_core");
    end
    $finish;
  end

endmodule
